### rtl/core/keyed_table_oldest_evict_defines.svh
// Assertion macros shared by the keyed table RTL.
// No dependencies; included by the modules that carry checks.
`ifndef KEYED_TABLE_OLDEST_EVICT_DEFINES_SVH
`define KEYED_TABLE_OLDEST_EVICT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KTO_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("keyed table check failed");

// Next-cycle implication, disabled while reset is asserted.
`define KTO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("keyed table check failed");

`endif

### rtl/core/kto_pkg.sv
// Shared types and constants of the keyed table.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package kto_pkg;

    localparam int SLOTS  = 8;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    // Field widths of the transfer payloads
    localparam int CMD_W      = 2;
    localparam int WORD_W     = 64;
    localparam int IDX_W      = 4;
    localparam int USED_W     = 3;
    localparam int SEQ_W      = 32;
    localparam int CNT_OUT_W  = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD     = 2'd0,
        CMD_DISMISS = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_READ    = 2'd3
    } t_command;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic scan_step;
        logic commit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;
    } t_dp_sts;

endpackage

`default_nettype wire

### rtl/core/kto_ctrl.sv
// Sequencing state machine of the keyed table.
// Depends on kto_pkg and keyed_table_oldest_evict_defines.svh.
`default_nettype none
`include "keyed_table_oldest_evict_defines.svh"

module kto_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [kto_pkg::CMD_W-1:0] i_command,
    output logic             o_valid,
    input  logic             i_stall,
    output kto_pkg::t_dp_cmd o_cmd,
    input  kto_pkg::t_dp_sts i_sts
);
    import kto_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;
    logic   needs_scan;

    assign out_free   = !r_out_valid || !i_stall;
    assign needs_scan = (t_command'(i_command) == CMD_ADD) ||
                        (t_command'(i_command) == CMD_DISMISS);

    assign o_stall         = (r_state != ST_IDLE);
    assign o_valid         = r_out_valid;
    assign o_cmd.capture   = (r_state == ST_IDLE) && i_valid;
    assign o_cmd.scan_step = (r_state == ST_SCAN);
    assign o_cmd.commit    = (r_state == ST_COMMIT) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // a commit in the same cycle reloads the result instead
            if (r_out_valid && !i_stall && !o_cmd.commit) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_state <= needs_scan ? ST_SCAN : ST_COMMIT;
                    end
                end
                ST_SCAN: begin
                    if (i_sts.scan_last) begin
                        r_state <= ST_COMMIT;
                    end
                end
                ST_COMMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // a result is never loaded over one still waiting
    `KTO_ASSERT_NOW(a_commit_free, i_clk, i_rst_n, o_cmd.commit, !r_out_valid || !i_stall)
    `KTO_ASSERT_NEXT(a_commit_shows, i_clk, i_rst_n, o_cmd.commit, r_out_valid)
    `KTO_ASSERT_NOW(a_idle_quiet, i_clk, i_rst_n, !o_stall, !o_cmd.scan_step && !o_cmd.commit)

endmodule

`default_nettype wire

### rtl/core/kto_dp.sv
// Slot storage, sequential scan and result register of the keyed table.
// Depends on kto_pkg and keyed_table_oldest_evict_defines.svh.
`default_nettype none
`include "keyed_table_oldest_evict_defines.svh"

module kto_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kto_pkg::t_dp_cmd              i_cmd,
    output kto_pkg::t_dp_sts              o_sts,
    input  logic [kto_pkg::CMD_W-1:0]     i_command,
    input  logic [kto_pkg::WORD_W-1:0]    i_key,
    input  logic [kto_pkg::WORD_W-1:0]    i_project_word,
    input  logic [kto_pkg::WORD_W-1:0]    i_message_word,
    input  logic [kto_pkg::IDX_W-1:0]     i_index,
    output logic                          o_status,
    output logic [kto_pkg::USED_W-1:0]    o_slot_used,
    output logic [kto_pkg::WORD_W-1:0]    o_entry_key,
    output logic [kto_pkg::WORD_W-1:0]    o_entry_project,
    output logic [kto_pkg::WORD_W-1:0]    o_entry_message,
    output logic [kto_pkg::SEQ_W-1:0]     o_entry_seq,
    output logic [kto_pkg::CNT_OUT_W-1:0] o_entry_count
);
    import kto_pkg::*;

    // slot table
    logic [SLOTS-1:0]  r_valid;
    logic [WORD_W-1:0] r_key  [SLOTS];
    logic [WORD_W-1:0] r_proj [SLOTS];
    logic [WORD_W-1:0] r_msg  [SLOTS];
    logic [SEQ_W-1:0]  r_seq  [SLOTS];
    logic [SEQ_W-1:0]  r_stamp;
    logic [CNT_W-1:0]  r_count;

    // captured item
    t_command          r_op;
    logic [WORD_W-1:0] r_in_key;
    logic [WORD_W-1:0] r_in_proj;
    logic [WORD_W-1:0] r_in_msg;
    logic [IDX_W-1:0]  r_in_idx;

    // scan state
    logic [SLOT_W-1:0] r_ptr;
    logic              r_hit;
    logic [SLOT_W-1:0] r_hit_slot;
    logic              r_free_found;
    logic [SLOT_W-1:0] r_free_slot;
    logic [SLOT_W-1:0] r_old_slot;
    logic [SEQ_W-1:0]  r_old_seq;

    // result register
    logic              r_o_status;
    logic [USED_W-1:0] r_o_used;
    logic [WORD_W-1:0] r_o_key;
    logic [WORD_W-1:0] r_o_proj;
    logic [WORD_W-1:0] r_o_msg;
    logic [SEQ_W-1:0]  r_o_seq;
    logic [CNT_W-1:0]  r_o_count;

    logic              n_o_status;
    logic [USED_W-1:0] n_o_used;
    logic [WORD_W-1:0] n_o_key;
    logic [WORD_W-1:0] n_o_proj;
    logic [WORD_W-1:0] n_o_msg;
    logic [SEQ_W-1:0]  n_o_seq;

    logic              rd_valid;
    logic [WORD_W-1:0] rd_key;
    logic [SEQ_W-1:0]  rd_seq;
    logic [SLOT_W-1:0] add_slot;
    logic              add_new;
    logic              in_range;
    logic [CNT_W-1:0]  n_count;

    // single read port, addressed by the scan pointer
    assign rd_valid = r_valid[r_ptr];
    assign rd_key   = r_key[r_ptr];
    assign rd_seq   = r_seq[r_ptr];

    assign o_sts.scan_last = (r_ptr == SLOT_W'(SLOTS - 1));

    assign add_new  = !r_hit && r_free_found;
    assign add_slot = r_hit ? r_hit_slot : (r_free_found ? r_free_slot : r_old_slot);
    assign in_range = (32'(r_in_idx) < 32'(SLOTS));

    always_comb begin
        n_count = r_count;
        case (r_op)
            CMD_ADD:     if (add_new) n_count = r_count + CNT_W'(1);
            CMD_DISMISS: if (r_hit) n_count = r_count - CNT_W'(1);
            CMD_CLEAR:   n_count = '0;
            default:     n_count = r_count;
        endcase
    end

    // result of the item being committed
    always_comb begin
        n_o_status = 1'b0;
        n_o_used   = '0;
        n_o_key    = '0;
        n_o_proj   = '0;
        n_o_msg    = '0;
        n_o_seq    = '0;
        case (r_op)
            CMD_ADD: begin
                n_o_used = USED_W'(add_slot);
            end
            CMD_DISMISS: begin
                if (r_hit) begin
                    n_o_used = USED_W'(r_hit_slot);
                end else begin
                    n_o_status = 1'b1;
                end
            end
            CMD_READ: begin
                if (in_range && rd_valid) begin
                    n_o_used = USED_W'(r_ptr);
                    n_o_key  = rd_key;
                    n_o_proj = r_proj[r_ptr];
                    n_o_msg  = r_msg[r_ptr];
                    n_o_seq  = rd_seq;
                end else begin
                    n_o_status = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_stamp <= '0;
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
            case (r_op)
                CMD_ADD: begin
                    r_valid[add_slot] <= 1'b1;
                    r_stamp           <= r_stamp + SEQ_W'(1);
                end
                CMD_DISMISS: begin
                    if (r_hit) r_valid[r_hit_slot] <= 1'b0;
                end
                CMD_CLEAR: begin
                    r_valid <= '0;
                    r_stamp <= '0;
                end
                default: ;
            endcase
        end
    end

    // payload: slot contents, captured item, scan trackers, result
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op         <= t_command'(i_command);
            r_in_key     <= i_key;
            r_in_proj    <= i_project_word;
            r_in_msg     <= i_message_word;
            r_in_idx     <= i_index;
            r_ptr        <= (t_command'(i_command) == CMD_READ) ? SLOT_W'(i_index) : '0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
        end
        if (i_cmd.scan_step) begin
            r_ptr <= r_ptr + SLOT_W'(1);
            if (!r_hit && rd_valid && (rd_key == r_in_key)) begin
                r_hit      <= 1'b1;
                r_hit_slot <= r_ptr;
            end
            if (!r_free_found && !rd_valid) begin
                r_free_found <= 1'b1;
                r_free_slot  <= r_ptr;
            end
            // strict less-than keeps the lowest index on equal stamps
            if ((r_ptr == '0) || (rd_seq < r_old_seq)) begin
                r_old_slot <= r_ptr;
                r_old_seq  <= rd_seq;
            end
        end
        if (i_cmd.commit) begin
            r_o_status <= n_o_status;
            r_o_used   <= n_o_used;
            r_o_key    <= n_o_key;
            r_o_proj   <= n_o_proj;
            r_o_msg    <= n_o_msg;
            r_o_seq    <= n_o_seq;
            r_o_count  <= n_count;
            if (r_op == CMD_ADD) begin
                r_key[add_slot]  <= r_in_key;
                r_proj[add_slot] <= r_in_proj;
                r_msg[add_slot]  <= r_in_msg;
                r_seq[add_slot]  <= r_stamp;
            end
        end
    end

    assign o_status        = r_o_status;
    assign o_slot_used     = r_o_used;
    assign o_entry_key     = r_o_key;
    assign o_entry_project = r_o_proj;
    assign o_entry_message = r_o_msg;
    assign o_entry_seq     = r_o_seq;
    assign o_entry_count   = CNT_OUT_W'(r_o_count);

    `KTO_ASSERT_NOW(a_count_tracks, i_clk, i_rst_n, 1'b1, 32'(r_count) == $countones(r_valid))
    `KTO_ASSERT_NEXT(a_stamp_hold, i_clk, i_rst_n, !i_cmd.commit, $stable(r_stamp))
    `KTO_ASSERT_NOW(a_one_phase, i_clk, i_rst_n, 1'b1,
        $onehot0({i_cmd.capture, i_cmd.scan_step, i_cmd.commit}))

endmodule

`default_nettype wire

### rtl/core/keyed_table_oldest_evict.sv
// Top level of the keyed table: controller plus datapath.
// Depends on kto_pkg, kto_ctrl and kto_dp.
//
// Keyed table of eight entries (key, two payload words, 32-bit stamp) with
// oldest-entry replacement. One item is in work at a time. Add and dismiss
// walk the slots through a single read port, one slot a cycle, to find the
// matching key, the lowest free slot and the lowest stamp; an item passes
// through accept, the scan of all slots and commit. Clear and read-by-index
// skip the walk and go from accept straight to commit. The result sits
// in an output register; the next input transfer is taken in the cycle after
// the commit, while that result may still be waiting downstream. A commit
// waits while the output register holds an untaken result. Stamps compare as
// plain unsigned numbers, so after a wrap the replacement picks the lowest
// value, not the least recent write. Reset and clear empty the table at once.
`default_nettype none

module keyed_table_oldest_evict (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [kto_pkg::CMD_W-1:0]     i_command,
    input  logic [kto_pkg::WORD_W-1:0]    i_key,
    input  logic [kto_pkg::WORD_W-1:0]    i_project_word,
    input  logic [kto_pkg::WORD_W-1:0]    i_message_word,
    input  logic [kto_pkg::IDX_W-1:0]     i_index,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_status,
    output logic [kto_pkg::USED_W-1:0]    o_slot_used,
    output logic [kto_pkg::WORD_W-1:0]    o_entry_key,
    output logic [kto_pkg::WORD_W-1:0]    o_entry_project,
    output logic [kto_pkg::WORD_W-1:0]    o_entry_message,
    output logic [kto_pkg::SEQ_W-1:0]     o_entry_seq,
    output logic [kto_pkg::CNT_OUT_W-1:0] o_entry_count
);
    import kto_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequencing: accept, scan, commit
    kto_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_command (i_command),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_cmd     (dp_cmd),
        .i_sts     (dp_sts)
    );

    // table, scan trackers and result register
    kto_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_sts           (dp_sts),
        .i_command       (i_command),
        .i_key           (i_key),
        .i_project_word  (i_project_word),
        .i_message_word  (i_message_word),
        .i_index         (i_index),
        .o_status        (o_status),
        .o_slot_used     (o_slot_used),
        .o_entry_key     (o_entry_key),
        .o_entry_project (o_entry_project),
        .o_entry_message (o_entry_message),
        .o_entry_seq     (o_entry_seq),
        .o_entry_count   (o_entry_count)
    );

endmodule

`default_nettype wire
